### design/shc_pkg.sv
// Types, codes and helper functions shared by the session handshake controller.
package shc_pkg;

   // Request kinds
   localparam logic [1:0] KIND_OPEN = 2'd0;
   localparam logic [1:0] KIND_SEND = 2'd1;
   localparam logic [1:0] KIND_RX   = 2'd2;

   // Link state codes as reported on the result channel
   localparam logic [1:0] LINK_CODE_RESET       = 2'd0;
   localparam logic [1:0] LINK_CODE_START_SENT  = 2'd1;
   localparam logic [1:0] LINK_CODE_ESTABLISHED = 2'd2;

   // Configuration register indexes
   localparam logic CSR_START_TYPE = 1'b0;
   localparam logic CSR_LOG_TYPE   = 1'b1;

   localparam logic [7:0] START_TYPE_RESET = 8'd0;
   localparam logic [7:0] LOG_TYPE_RESET   = 8'd1;

   typedef enum logic [2:0] {
      LINK_RESET       = 3'b001,
      LINK_START_SENT  = 3'b010,
      LINK_ESTABLISHED = 3'b100
   } link_mode_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        rx_ok;
      logic [15:0] hdr_sess_id;
      logic [7:0]  pkt_type;
   } shc_item_type;

   typedef struct packed {
      link_mode_type mode;
      logic [7:0]    nonce;
      logic [15:0]   sess_id;
   } shc_state_type;

   typedef struct packed {
      logic [7:0] start_type_code;
      logic [7:0] log_type_code;
   } shc_cfg_type;

   typedef struct packed {
      logic        tx_header;
      logic [15:0] tx_sess_id;
      logic [7:0]  tx_pkt_type;
      logic        send_refused;
      logic        deliver;
      logic [1:0]  link_state;
   } shc_result_type;

   // Rotate-style mix: bits 3 and 4 fall out, then +1, zero maps to one.
   function automatic logic [7:0] next_nonce(input logic [7:0] n);
      logic [7:0] m;
      m = {n[2:0], 2'b00, n[7:5]} + 8'd1;
      return (m == 8'd0) ? 8'd1 : m;
   endfunction

   function automatic logic [1:0] link_code(input link_mode_type mode);
      logic [1:0] code;
      case (mode)
         LINK_START_SENT:  code = LINK_CODE_START_SENT;
         LINK_ESTABLISHED: code = LINK_CODE_ESTABLISHED;
         default:          code = LINK_CODE_RESET;
      endcase
      return code;
   endfunction

endpackage

### design/shc_step.sv
// Next-state and result logic for one request of the session controller.
module shc_step import shc_pkg::*; (
   input  shc_item_type   item,
   input  shc_state_type  state,
   input  shc_cfg_type    cfg,
   output shc_state_type  state_next,
   output shc_result_type result
);

   logic [7:0]  nonce_adv;
   logic [7:0]  hid_lo;
   logic [7:0]  hid_hi;
   logic        id_match;
   logic        do_open;
   logic        do_reply;

   assign nonce_adv = next_nonce(state.nonce);
   assign hid_lo    = item.hdr_sess_id[7:0];
   assign hid_hi    = item.hdr_sess_id[15:8];
   assign id_match  = (item.hdr_sess_id == state.sess_id);

   always_comb begin
      state_next            = state;
      result                = '0;
      do_open               = 1'b0;
      do_reply              = 1'b0;

      case (item.kind)
         KIND_OPEN: begin
            do_open = 1'b1;
         end
         KIND_SEND: begin
            if (state.mode == LINK_ESTABLISHED) begin
               result.tx_header   = 1'b1;
               result.tx_sess_id  = state.sess_id;
               result.tx_pkt_type = item.pkt_type;
            end else begin
               result.send_refused = 1'b1;
            end
         end
         KIND_RX: begin
            if (item.rx_ok) begin
               if (id_match) begin
                  if (item.pkt_type == cfg.start_type_code) begin
                     // handshake on a start packet
                     case (state.mode)
                        LINK_RESET: begin
                           if (hid_lo != 8'd0 && hid_hi == 8'd0) begin
                              do_reply        = 1'b1;
                              state_next.mode = LINK_ESTABLISHED;
                           end else begin
                              do_open = 1'b1;
                           end
                        end
                        LINK_START_SENT: begin
                           if (hid_lo == state.nonce) begin
                              state_next.sess_id = item.hdr_sess_id;
                              state_next.mode    = LINK_ESTABLISHED;
                           end else begin
                              do_open = 1'b1;
                           end
                        end
                        LINK_ESTABLISHED: begin
                           if (!id_match && hid_hi == 8'd0) begin
                              do_reply = 1'b1;
                           end else begin
                              state_next.mode = LINK_RESET;
                           end
                        end
                        default: begin
                           state_next.mode = LINK_RESET;
                        end
                     endcase
                  end else if (state.mode == LINK_ESTABLISHED) begin
                     result.deliver = 1'b1;
                  end
               end else if (item.hdr_sess_id == 16'd0 &&
                            item.pkt_type == cfg.log_type_code) begin
                  result.deliver = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      if (do_open) begin
         state_next.nonce   = nonce_adv;
         state_next.sess_id = {8'd0, nonce_adv};
         state_next.mode    = LINK_START_SENT;
      end
      if (do_reply) begin
         state_next.nonce   = nonce_adv;
         state_next.sess_id = {nonce_adv, hid_lo};
      end
      if (do_open || do_reply) begin
         result.tx_header   = 1'b1;
         result.tx_sess_id  = state_next.sess_id;
         result.tx_pkt_type = cfg.start_type_code;
      end

      result.link_state = link_code(state_next.mode);
   end

endmodule

### design/session_handshake_controller_unit.sv
// Top level of the session handshake controller: request/response channels and CSRs.
//
// Session layer of a framed link. Each request on the req_ channel is one of:
// open a session, send a packet, or report a finished received header. Every
// request gives exactly one response on the rsp_ channel: a header to send
// (tx_header with id and type), a refusal flag, a deliver flag and the link
// state after the request.
// Both channels are valid/ready. A request is captured in an input register;
// while it waits there the session logic evaluates it against the link state;
// once the output register is empty or being drained, the state is updated and
// the response lands in the output register. Throughput is one request per
// cycle while rsp_ready stays high, with the state update lying between the
// two registers.
// A stalled receiver holds the response; one more request may wait in the
// input register, after which req_ready drops until rsp_ready returns.
// The csr_ channel writes the start and log type codes; it is always ready
// and is meant to be used only while no request is in flight.
// Synchronous reset empties both registers, puts the link in reset with nonce
// and session id zero, and restores the type codes (start 0, log 1).
module session_handshake_controller_unit import shc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic        req_rx_ok,
   input  logic [15:0] req_hdr_sess_id,
   input  logic [7:0]  req_pkt_type,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_header,
   output logic [15:0] rsp_tx_sess_id,
   output logic [7:0]  rsp_tx_pkt_type,
   output logic        rsp_send_refused,
   output logic        rsp_deliver,
   output logic [1:0]  rsp_link_state,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   // input register
   logic           in_valid_ff, in_valid_in;
   shc_item_type   item_ff;
   // output register
   logic           out_valid_ff, out_valid_in;
   shc_result_type result_ff;
   // session state and configuration
   shc_state_type  state_ff, state_in;
   shc_cfg_type    cfg_ff, cfg_in;

   shc_result_type result_in;
   logic           req_take;
   logic           advance;

   // A request moves on when the output register is empty or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   shc_step u_step (
      .item       (item_ff),
      .state      (state_ff),
      .cfg        (cfg_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_TYPE: cfg_in.start_type_code = csr_data;
            CSR_LOG_TYPE:   cfg_in.log_type_code   = csr_data;
            default: begin
            end
         endcase
      end
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                <= 1'b0;
         out_valid_ff               <= 1'b0;
         state_ff.mode              <= LINK_RESET;
         state_ff.nonce             <= 8'd0;
         state_ff.sess_id           <= 16'd0;
         cfg_ff.start_type_code     <= START_TYPE_RESET;
         cfg_ff.log_type_code       <= LOG_TYPE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.kind        <= req_kind;
         item_ff.rx_ok       <= req_rx_ok;
         item_ff.hdr_sess_id <= req_hdr_sess_id;
         item_ff.pkt_type    <= req_pkt_type;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_tx_header    = result_ff.tx_header;
   assign rsp_tx_sess_id   = result_ff.tx_sess_id;
   assign rsp_tx_pkt_type  = result_ff.tx_pkt_type;
   assign rsp_send_refused = result_ff.send_refused;
   assign rsp_deliver      = result_ff.deliver;
   assign rsp_link_state   = result_ff.link_state;

   // at most one of header, refusal and delivery per response
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_tx_header, rsp_send_refused, rsp_deliver}) <= 1)
      else $error("more than one action in a response");

   // link state register stays one-hot
   a_mode_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff.mode))
      else $error("link mode not one-hot");

   // an open request leaves the link in start sent with a non-zero nonce
   a_open_effect: assert property (@(posedge clock) disable iff (reset)
      (advance && item_ff.kind == KIND_OPEN) |=>
         (state_ff.mode == LINK_START_SENT && state_ff.nonce != 8'd0))
      else $error("open request did not start a session");

   // a held response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !advance)
      else $error("response overwritten while stalled");

   // a refused send never reports an established link
   a_refuse_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_send_refused) |-> (rsp_link_state != LINK_CODE_ESTABLISHED))
      else $error("send refused while established");

endmodule

### verif/shc_checker.sv
// Checker for the session handshake controller: predicts each response and compares it.
module shc_checker import shc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic        req_rx_ok,
   input  logic [15:0] req_hdr_sess_id,
   input  logic [7:0]  req_pkt_type,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_tx_header,
   input  logic [15:0] rsp_tx_sess_id,
   input  logic [7:0]  rsp_tx_pkt_type,
   input  logic        rsp_send_refused,
   input  logic        rsp_deliver,
   input  logic [1:0]  rsp_link_state,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data,
   output int          fail_count,
   output int          outstanding,
   output logic [15:0] live_sess_id
);
   timeunit 1ns;
   timeprecision 1ps;

   shc_cfg_type    type_codes;
   logic [1:0]     mode;
   logic [7:0]     nonce;
   logic [15:0]    sess_id;
   shc_result_type next_response;
   shc_result_type pending_responses[$];

   function automatic logic [7:0] mixed_nonce(input logic [7:0] n);
      logic [7:0] m;
      m = ((n << 5) | (n >> 5)) + 8'd1;
      if (m == 8'd0) begin
         m = 8'd1;
      end
      return m;
   endfunction

   function void send_start();
      next_response.tx_header   = 1'b1;
      next_response.tx_sess_id  = sess_id;
      next_response.tx_pkt_type = type_codes.start_type_code;
   endfunction

   function void open_link();
      nonce   = mixed_nonce(nonce);
      sess_id = {8'h00, nonce};
      send_start();
      mode    = LINK_CODE_START_SENT;
   endfunction

   // peer opened: keep its low byte, our nonce goes on top
   function void answer_start(input logic [15:0] hid);
      nonce   = mixed_nonce(nonce);
      sess_id = {nonce, hid[7:0]};
      send_start();
   endfunction

   function void take_start(input logic [15:0] hid);
      case (mode)
         LINK_CODE_RESET: begin
            if (hid[7:0] != 8'h00 && hid[15:8] == 8'h00) begin
               answer_start(hid);
               mode = LINK_CODE_ESTABLISHED;
            end else begin
               open_link();
            end
         end
         LINK_CODE_START_SENT: begin
            if (hid[7:0] == nonce) begin
               sess_id = hid;
               mode    = LINK_CODE_ESTABLISHED;
            end else begin
               open_link();
            end
         end
         LINK_CODE_ESTABLISHED: begin
            if (hid != sess_id && hid[15:8] == 8'h00) begin
               answer_start(hid);
            end else begin
               mode = LINK_CODE_RESET;
            end
         end
         default: begin
            mode = LINK_CODE_RESET;
         end
      endcase
   endfunction

   function void session_step(input shc_item_type it);
      next_response = '0;
      case (it.kind)
         KIND_OPEN: begin
            open_link();
         end
         KIND_SEND: begin
            if (mode == LINK_CODE_ESTABLISHED) begin
               next_response.tx_header   = 1'b1;
               next_response.tx_sess_id  = sess_id;
               next_response.tx_pkt_type = it.pkt_type;
            end else begin
               next_response.send_refused = 1'b1;
            end
         end
         KIND_RX: begin
            if (it.rx_ok) begin
               if (it.hdr_sess_id == sess_id) begin
                  if (it.pkt_type == type_codes.start_type_code) begin
                     take_start(it.hdr_sess_id);
                  end else if (mode == LINK_CODE_ESTABLISHED) begin
                     next_response.deliver = 1'b1;
                  end
               end else if (it.hdr_sess_id == 16'h0000 &&
                            it.pkt_type == type_codes.log_type_code) begin
                  next_response.deliver = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      next_response.link_state = mode;
   endfunction

   task automatic note_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("mismatch on %s: expected %0h, got %0h", field, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      shc_item_type   item;
      shc_result_type want;
      if (reset) begin
         type_codes.start_type_code = START_TYPE_RESET;
         type_codes.log_type_code   = LOG_TYPE_RESET;
         mode    = LINK_CODE_RESET;
         nonce   = 8'h00;
         sess_id = 16'h0000;
         pending_responses.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_START_TYPE) begin
               type_codes.start_type_code = csr_data;
            end else begin
               type_codes.log_type_code = csr_data;
            end
         end
         if (req_valid && req_ready) begin
            item = {req_kind, req_rx_ok, req_hdr_sess_id, req_pkt_type};
            session_step(item);
            pending_responses.push_back(next_response);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_responses.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("response with no request waiting: tx %0b id %0h type %0h",
                           rsp_tx_header, rsp_tx_sess_id, rsp_tx_pkt_type);
               end
            end else begin
               want = pending_responses.pop_front();
               note_field("tx_header", 16'(want.tx_header), 16'(rsp_tx_header));
               note_field("tx_sess_id", want.tx_sess_id, rsp_tx_sess_id);
               note_field("tx_pkt_type", 16'(want.tx_pkt_type), 16'(rsp_tx_pkt_type));
               note_field("send_refused", 16'(want.send_refused), 16'(rsp_send_refused));
               note_field("deliver", 16'(want.deliver), 16'(rsp_deliver));
               note_field("link_state", 16'(want.link_state), 16'(rsp_link_state));
            end
         end
      end
      // registered so the stimulus side reads a settled value next cycle
      outstanding  <= pending_responses.size();
      live_sess_id <= sess_id;
   end

endmodule

### verif/tb_session_handshake_controller_unit.sv
// Testbench top for the session handshake controller: stimulus, idling and verdict.
module tb_session_handshake_controller_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import shc_pkg::*;

   // kind code with no meaning; the block must ignore it apart from the response
   localparam logic [1:0] KIND_SPARE = 2'd3;
   // cycles with no handshake at all before we give up
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_REQUESTS = 170;

   // header id either given by the caller or taken from the live session id
   typedef enum logic {HDR_FIXED, HDR_LIVE} hdr_src_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind = KIND_OPEN;
   logic        req_rx_ok = 1'b0;
   logic [15:0] req_hdr_sess_id = 16'h0000;
   logic [7:0]  req_pkt_type = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_tx_header;
   logic [15:0] rsp_tx_sess_id;
   logic [7:0]  rsp_tx_pkt_type;
   logic        rsp_send_refused;
   logic        rsp_deliver;
   logic [1:0]  rsp_link_state;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_START_TYPE;
   logic [7:0]  csr_data = 8'h00;

   int          fail_count;
   int          outstanding;
   logic [15:0] live_sess_id;

   // random idling on both sides; switched off for one long stretch
   logic        idle_on = 1'b1;
   // set when the last request went in at the current edge
   bit          just_accepted = 1'b0;
   logic [7:0]  start_code = START_TYPE_RESET;
   logic [7:0]  log_code = LOG_TYPE_RESET;

   always #5 clock = ~clock;

   session_handshake_controller_unit uut (.*);

   shc_checker u_check (.*);

   // Response side: stalls about one cycle in ten while idling is on.
   always @(posedge clock) begin
      rsp_ready <= (idle_on && $urandom_range(99) < 10) ? 1'b0 : 1'b1;
   end

   task automatic idle_cycle();
      req_valid <= 1'b0;
      @(posedge clock);
      just_accepted = 1'b0;
   endtask

   // One request. A header that must carry the live session id is held back by
   // idle_cycle() after the previous request, so the checker's registered copy has caught up.
   task automatic push_request(input logic [1:0] kind, input logic rx_ok,
                               input hdr_src_type src, input logic [15:0] hid,
                               input logic [7:0] ptype);
      while (idle_on && $urandom_range(99) < 10) begin
         idle_cycle();
      end
      if (src == HDR_LIVE && just_accepted) begin
         idle_cycle();
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_rx_ok       <= rx_ok;
      req_hdr_sess_id <= (src == HDR_LIVE) ? live_sess_id : hid;
      req_pkt_type    <= ptype;
      do @(posedge clock); while (!req_ready);
      just_accepted = 1'b1;
   endtask

   // Wait until every request has had its response.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Both type codes, back to back with valid held high.
   task automatic set_type_codes(input logic [7:0] st, input logic [7:0] lg);
      csr_valid <= 1'b1;
      csr_index <= CSR_START_TYPE;
      csr_data  <= st;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_LOG_TYPE;
      csr_data  <= lg;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      start_code = st;
      log_code   = lg;
   endtask

   // Mostly well-formed traffic against the live session, with some noise.
   task automatic random_request();
      int          pick;
      logic [15:0] any_id;
      pick = $urandom_range(99);
      case ($urandom_range(3))
         0:       any_id = 16'h0000;
         1:       any_id = 16'hffff;
         default: any_id = 16'($urandom_range(16'hffff));
      endcase
      if (pick < 8) begin
         // noise: anything, the spare kind included
         push_request(2'($urandom_range(3)), 1'($urandom_range(1)), HDR_FIXED, any_id,
                      8'($urandom_range(255)));
      end else if (pick < 20) begin
         push_request(KIND_OPEN, 1'($urandom_range(1)), HDR_FIXED, any_id,
                      8'($urandom_range(255)));
      end else if (pick < 38) begin
         push_request(KIND_SEND, 1'($urandom_range(1)), HDR_FIXED, any_id,
                      8'($urandom_range(255)));
      end else if (pick < 58) begin
         // start packet on the current session: drives the handshake along
         push_request(KIND_RX, 1'b1, HDR_LIVE, 16'h0000, start_code);
      end else if (pick < 80) begin
         push_request(KIND_RX, 1'b1, HDR_LIVE, 16'h0000, 8'($urandom_range(255)));
      end else if (pick < 90) begin
         push_request(KIND_RX, 1'b1, HDR_FIXED, 16'h0000, log_code);
      end else if (pick < 95) begin
         // would have been a start packet, but the frame was bad
         push_request(KIND_RX, 1'b0, HDR_LIVE, 16'h0000, start_code);
      end else begin
         push_request(KIND_RX, 1'b1, HDR_FIXED, any_id, start_code);
      end
   endtask

   initial begin : stimulus
      logic [7:0] st_list[4];
      logic [7:0] lg_list[4];
      st_list = '{8'hff, 8'h5a, 8'h00, 8'h00};
      lg_list = '{8'h00, 8'h5a, 8'hff, 8'h00};
      st_list[3] = 8'($urandom_range(255));
      lg_list[3] = 8'($urandom_range(255));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed walk with the reset type codes (start 0, log 1).
      push_request(KIND_SEND, 1'b1, HDR_FIXED, 16'hffff, 8'hff);  // refused before open
      push_request(KIND_SPARE, 1'b1, HDR_FIXED, 16'hffff, 8'hff); // ignored kind
      push_request(KIND_RX, 1'b0, HDR_FIXED, 16'h0000, 8'h00);    // bad frame dropped
      // log packet on id zero while the session id is still zero: not delivered
      push_request(KIND_RX, 1'b1, HDR_FIXED, 16'h0000, 8'h01);
      push_request(KIND_RX, 1'b1, HDR_FIXED, 16'hffff, 8'h01);    // foreign id
      push_request(KIND_RX, 1'b1, HDR_LIVE, 16'h0000, 8'h00);     // start on id 0: open
      push_request(KIND_SEND, 1'b0, HDR_FIXED, 16'h0000, 8'h00);  // refused, start sent
      push_request(KIND_RX, 1'b1, HDR_FIXED, 16'h0000, 8'h01);    // log delivered
      push_request(KIND_RX, 1'b1, HDR_LIVE, 16'h0000, 8'h00);     // nonce echoed: up
      push_request(KIND_SEND, 1'b0, HDR_FIXED, 16'h0000, 8'ha5);
      push_request(KIND_RX, 1'b1, HDR_LIVE, 16'h0000, 8'h80);     // data delivered
      push_request(KIND_RX, 1'b1, HDR_LIVE, 16'h0000, 8'h00);     // start while up: down
      push_request(KIND_RX, 1'b1, HDR_LIVE, 16'h0000, 8'h00);     // low id only: reply
      push_request(KIND_RX, 1'b1, HDR_LIVE, 16'h0000, 8'h00);     // back down
      push_request(KIND_RX, 1'b1, HDR_LIVE, 16'h0000, 8'h00);     // high byte set: open
      push_request(KIND_OPEN, 1'b1, HDR_FIXED, 16'hffff, 8'hff);
      push_request(KIND_RX, 1'b1, HDR_LIVE, 16'h0000, 8'h00);
      push_request(KIND_SEND, 1'b1, HDR_FIXED, 16'hffff, 8'hff);

      // Random phases, each under its own pair of type codes.
      for (int p = 0; p < 4; p++) begin
         drain();
         idle_on <= (p != 2);
         set_type_codes(st_list[p], lg_list[p]);
         if (st_list[p] == lg_list[p]) begin
            // same code for start and log: a matching id counts as a start
            push_request(KIND_RX, 1'b1, HDR_LIVE, 16'h0000, start_code);
            push_request(KIND_RX, 1'b1, HDR_FIXED, 16'h0000, log_code);
         end
         repeat (PHASE_REQUESTS) random_request();
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog: too long without any handshake ends the run.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("simulation failed");
      $finish;
   end

endmodule
